FILE: src/ehfc_pkg.sv
package ehfc_pkg;

   localparam int TABLE_ENTRIES = 32;
   // wide enough to hold the entry count itself
   localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [15:0] LLDP_PROTO = 16'h88cc;
   localparam logic [15:0] IPV4_PROTO = 16'h0800;
   localparam logic [47:0] LLDP_GROUP = 48'h0180_c200_0000;
   localparam logic [47:0] LLDP_TPMR  = 48'h0180_c200_0003;
   localparam logic [47:0] LLDP_NB    = 48'h0180_c200_000e;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   typedef enum logic [1:0] {
      CMD_CLASSIFY = 2'd0,
      CMD_ADD_IP   = 2'd1,
      CMD_ADD_MAC  = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOCAL_IP  = 3'd0,
      CSR_LOCAL_MAC = 3'd1,
      CSR_PXE_ONLY  = 3'd2,
      CSR_LIMIT     = 3'd3,
      CSR_NULL_MAC  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   typedef enum int {
      TAG_LLDP     = 0,
      TAG_PXE      = 1,
      TAG_L2_BCAST = 2,
      TAG_L2_TO    = 3,
      TAG_L2_FROM  = 4,
      TAG_L3_BCAST = 5,
      TAG_L3_TO    = 6,
      TAG_L3_FROM  = 7,
      TAG_DF       = 8,
      TAG_MF       = 9
   } tag_pos_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [47:0] dest_mac;
      logic [47:0] src_mac;
      logic [15:0] eth_proto;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [2:0]  frag_flags;
   } req_type;

   typedef struct packed {
      logic        dropped;
      logic        reported;
      logic [9:0]  tag_bits;
      logic        self_sent;
      logic [31:0] seen_total;
      logic [31:0] reported_total;
      logic        limit_reached;
      logic        table_full;
   } rsp_type;

   // drop table entries, shifted along the row on an add
   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
   } entry_type;

   // search key and running match flag, passed cell to cell
   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic        hit;
   } link_type;

   // controls from the top level into the row
   typedef struct packed {
      logic              ip_shift;
      logic              mac_shift;
      logic [USED_W-1:0] ip_used;
      logic [USED_W-1:0] mac_used;
   } row_ctrl_type;

endpackage

FILE: src/ehfc_cell.sv
module ehfc_cell (
   input  logic                clock,
   input  logic                ip_shift,
   input  logic                mac_shift,
   input  logic                ip_valid,
   input  logic                mac_valid,
   input  ehfc_pkg::entry_type entry_in,
   output ehfc_pkg::entry_type entry_out,
   input  ehfc_pkg::link_type  link_in,
   output ehfc_pkg::link_type  link_out
);

   ehfc_pkg::entry_type entry_ff;
   ehfc_pkg::link_type  link_ff;
   ehfc_pkg::link_type  link_in_next;

   always_comb begin
      link_in_next     = link_in;
      link_in_next.hit = link_in.hit
                       | (ip_valid  && (entry_ff.ip  == link_in.ip))
                       | (mac_valid && (entry_ff.mac == link_in.mac));
   end

   always_ff @(posedge clock) begin
      if (ip_shift) begin
         entry_ff.ip <= entry_in.ip;
      end
      if (mac_shift) begin
         entry_ff.mac <= entry_in.mac;
      end
      link_ff <= link_in_next;
   end

   assign entry_out = entry_ff;
   assign link_out  = link_ff;

endmodule

FILE: src/ehfc_row.sv
module ehfc_row (
   input  logic                   clock,
   input  ehfc_pkg::row_ctrl_type ctrl,
   input  ehfc_pkg::entry_type    new_entry,
   input  ehfc_pkg::link_type     key,
   output ehfc_pkg::link_type     result
);

   ehfc_pkg::entry_type entries [ehfc_pkg::TABLE_ENTRIES];
   ehfc_pkg::link_type  links   [ehfc_pkg::TABLE_ENTRIES];

   for (genvar i = 0; i < ehfc_pkg::TABLE_ENTRIES; i++) begin : g_cell
      ehfc_pkg::entry_type entry_from;
      ehfc_pkg::link_type  link_from;
      logic                ip_valid;
      logic                mac_valid;

      if (i == 0) begin : g_head
         assign entry_from = new_entry;
         assign link_from  = key;
      end else begin : g_body
         assign entry_from = entries[i-1];
         assign link_from  = links[i-1];
      end

      // newest entry sits in cell 0, so filled cells are the low ones
      assign ip_valid  = ctrl.ip_used  > ehfc_pkg::USED_W'(i);
      assign mac_valid = ctrl.mac_used > ehfc_pkg::USED_W'(i);

      ehfc_cell u_cell (
         .clock     (clock),
         .ip_shift  (ctrl.ip_shift),
         .mac_shift (ctrl.mac_shift),
         .ip_valid  (ip_valid),
         .mac_valid (mac_valid),
         .entry_in  (entry_from),
         .entry_out (entries[i]),
         .link_in   (link_from),
         .link_out  (links[i])
      );
   end

   assign result = links[ehfc_pkg::TABLE_ENTRIES-1];

endmodule

FILE: src/ethernet_header_filter_classifier_unit.sv
// Header filter and classifier. A transaction is taken when start is high and busy
// is low; its result appears on rsp_data for exactly one cycle with rsp_valid high
// and must be captured then. A classify transaction holds busy while the source MAC
// and IP travel through the row of table cells one cell per cycle, and its result
// strobes in the first cycle that busy is low again; no new item is taken while busy.
// Add and unused commands skip the search and hold busy only for the done state.
// A new transaction may be started in the same cycle as the previous result strobe.
// Configuration writes are always ready and should only be made while busy is low
// and no result is pending.
module ethernet_header_filter_classifier_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  ehfc_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   output ehfc_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ehfc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ehfc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam logic [ehfc_pkg::USED_W-1:0] LAST_CELL =
      ehfc_pkg::USED_W'(ehfc_pkg::TABLE_ENTRIES - 1);
   localparam logic [ehfc_pkg::USED_W-1:0] FULL_COUNT =
      ehfc_pkg::USED_W'(ehfc_pkg::TABLE_ENTRIES);

   ehfc_pkg::state_type state_ff, state_in;
   logic [ehfc_pkg::USED_W-1:0] count_ff, count_in;
   ehfc_pkg::req_type req_ff;

   logic [31:0] local_ip_ff;
   logic [47:0] local_mac_ff;
   logic        pxe_only_ff;
   logic [31:0] limit_ff;
   logic        null_mac_ff;

   logic [ehfc_pkg::USED_W-1:0] ip_used_ff, ip_used_in;
   logic [ehfc_pkg::USED_W-1:0] mac_used_ff, mac_used_in;
   logic [31:0] seen_ff, seen_in;
   logic [31:0] reported_ff, reported_in;
   logic        halted_ff, halted_in;

   logic              rsp_valid_ff, rsp_valid_in;
   ehfc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   ehfc_pkg::row_ctrl_type row_ctrl;
   ehfc_pkg::entry_type    new_entry;
   ehfc_pkg::link_type     key;
   ehfc_pkg::link_type     search_result;

   logic accept;
   logic pxe;
   logic self_hit;
   logic dropped;
   logic reported;
   logic [9:0] tags;

   assign accept    = start && !busy;
   assign busy      = state_ff != ehfc_pkg::ST_IDLE;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff  <= '0;
         local_mac_ff <= '0;
         pxe_only_ff  <= 1'b0;
         limit_ff     <= '0;
         null_mac_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ehfc_pkg::CSR_LOCAL_IP:  local_ip_ff  <= csr_data[31:0];
            ehfc_pkg::CSR_LOCAL_MAC: local_mac_ff <= csr_data[47:0];
            ehfc_pkg::CSR_PXE_ONLY:  pxe_only_ff  <= csr_data[0];
            ehfc_pkg::CSR_LIMIT:     limit_ff     <= csr_data[31:0];
            ehfc_pkg::CSR_NULL_MAC:  null_mac_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign key.ip  = req_ff.src_ip;
   assign key.mac = req_ff.src_mac;
   assign key.hit = 1'b0;

   assign new_entry.ip  = req_ff.src_ip;
   assign new_entry.mac = req_ff.src_mac;

   assign row_ctrl.ip_shift  = (state_ff == ehfc_pkg::ST_DONE)
                             && (req_ff.command == ehfc_pkg::CMD_ADD_IP)
                             && (ip_used_ff < FULL_COUNT);
   assign row_ctrl.mac_shift = (state_ff == ehfc_pkg::ST_DONE)
                             && (req_ff.command == ehfc_pkg::CMD_ADD_MAC)
                             && (mac_used_ff < FULL_COUNT);
   assign row_ctrl.ip_used   = ip_used_ff;
   assign row_ctrl.mac_used  = mac_used_ff;

   ehfc_row u_row (
      .clock     (clock),
      .ctrl      (row_ctrl),
      .new_entry (new_entry),
      .key       (key),
      .result    (search_result)
   );

   // frame classification from the finished search
   always_comb begin
      pxe      = (req_ff.src_ip == '0) && (req_ff.dst_ip == '1)
               && (req_ff.dest_mac == '1);
      self_hit = (local_ip_ff != '0) && (req_ff.src_ip == local_ip_ff);
      dropped  = search_result.hit || (null_mac_ff && (req_ff.src_mac == '0));
      reported = !dropped && (!pxe_only_ff || pxe);
      tags     = '0;
      if (!dropped && !pxe_only_ff) begin
         tags[ehfc_pkg::TAG_LLDP]     = (req_ff.eth_proto == ehfc_pkg::LLDP_PROTO)
                                      || (req_ff.dest_mac == ehfc_pkg::LLDP_GROUP)
                                      || (req_ff.dest_mac == ehfc_pkg::LLDP_TPMR)
                                      || (req_ff.dest_mac == ehfc_pkg::LLDP_NB);
         tags[ehfc_pkg::TAG_PXE]      = pxe;
         tags[ehfc_pkg::TAG_L2_BCAST] = req_ff.dest_mac == '1;
         tags[ehfc_pkg::TAG_L2_TO]    = req_ff.dest_mac == local_mac_ff;
         tags[ehfc_pkg::TAG_L2_FROM]  = req_ff.src_mac == local_mac_ff;
         if (req_ff.eth_proto == ehfc_pkg::IPV4_PROTO) begin
            tags[ehfc_pkg::TAG_L3_BCAST] = req_ff.dst_ip == '1;
            tags[ehfc_pkg::TAG_L3_TO]    = req_ff.dst_ip == local_ip_ff;
            tags[ehfc_pkg::TAG_L3_FROM]  = self_hit;
            tags[ehfc_pkg::TAG_DF]       = req_ff.frag_flags[1];
            tags[ehfc_pkg::TAG_MF]       = req_ff.frag_flags[0];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ip_used_in   = ip_used_ff;
      mac_used_in  = mac_used_ff;
      seen_in      = seen_ff;
      reported_in  = reported_ff;
      halted_in    = halted_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;

      case (state_ff)
         ehfc_pkg::ST_IDLE: begin
            count_in = '0;
            if (accept) begin
               if (req_data.command == ehfc_pkg::CMD_CLASSIFY) begin
                  state_in = ehfc_pkg::ST_SEARCH;
               end else begin
                  state_in = ehfc_pkg::ST_DONE;
               end
            end
         end
         ehfc_pkg::ST_SEARCH: begin
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_CELL) begin
               state_in = ehfc_pkg::ST_DONE;
            end
         end
         ehfc_pkg::ST_DONE: begin
            state_in     = ehfc_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            case (req_ff.command)
               ehfc_pkg::CMD_ADD_IP: begin
                  if (ip_used_ff < FULL_COUNT) begin
                     ip_used_in = ip_used_ff + 1'b1;
                  end else begin
                     rsp_data_in.table_full = 1'b1;
                  end
               end
               ehfc_pkg::CMD_ADD_MAC: begin
                  if (mac_used_ff < FULL_COUNT) begin
                     mac_used_in = mac_used_ff + 1'b1;
                  end else begin
                     rsp_data_in.table_full = 1'b1;
                  end
               end
               ehfc_pkg::CMD_CLASSIFY: begin
                  if (!halted_ff) begin
                     if (seen_ff != '1) begin
                        seen_in = seen_ff + 1'b1;
                     end
                     if (reported && (reported_ff != '1)) begin
                        reported_in = reported_ff + 1'b1;
                     end
                     if ((limit_ff != '0) && (reported_in >= limit_ff)) begin
                        halted_in = 1'b1;
                     end
                     rsp_data_in.dropped   = dropped;
                     rsp_data_in.reported  = reported;
                     rsp_data_in.tag_bits  = tags;
                     rsp_data_in.self_sent = reported && !pxe_only_ff && self_hit;
                  end
               end
               default: ;
            endcase
            rsp_data_in.seen_total     = seen_in;
            rsp_data_in.reported_total = reported_in;
            rsp_data_in.limit_reached  = halted_in;
         end
         default: begin
            state_in = ehfc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ehfc_pkg::ST_IDLE;
         count_ff     <= '0;
         ip_used_ff   <= '0;
         mac_used_ff  <= '0;
         seen_ff      <= '0;
         reported_ff  <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ip_used_ff   <= ip_used_in;
         mac_used_ff  <= mac_used_in;
         seen_ff      <= seen_in;
         reported_ff  <= reported_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (ip_used_ff <= FULL_COUNT) && (mac_used_ff <= FULL_COUNT))
      else $error("drop table fill count beyond table size");

   a_table_still: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ehfc_pkg::ST_SEARCH) |=> $stable(ip_used_ff) && $stable(mac_used_ff))
      else $error("drop table changed during a search");

   a_report_le_seen: assert property (@(posedge clock) disable iff (reset)
      reported_ff <= seen_ff)
      else $error("reported count exceeds seen count");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   a_strobe_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ehfc_pkg::ST_DONE))
      else $error("result strobe without a completed transaction");

endmodule
